// ===== rtl/rqid_pkg.sv =====
// shared types and constants for the ray/quadric intercept distance pipeline
// no dependencies
package rqid_pkg;

	localparam int COEF_W     = 32;
	localparam int MAG_W      = COEF_W + 1;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int NUM_W      = 34;
	localparam int DIST_W     = 32;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int DIV_STEPS  = DIST_W;
	localparam int REM_W      = NUM_W + DIV_STEPS;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
		logic                     outside_sense;
	} query_t;

	typedef struct packed {
		logic              hits;
		logic [DIST_W-1:0] distance;
	} result_t;

	// branch decision and operand magnitudes carried along the root pipeline
	typedef struct packed {
		logic             hit;
		logic             do_div;
		logic             root_num;
		logic [MAG_W-1:0] abs_a;
		logic [MAG_W-1:0] abs_b;
		logic [MAG_W-1:0] abs_c;
	} job_t;

	typedef struct packed {
		logic hit;
		logic do_div;
	} ctl_t;

endpackage

// ===== rtl/rqid_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on rqid_pkg
module rqid_sqrt import rqid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  job_t              in_job,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output job_t              out_job
);

	logic [RAD_W-1:0] rad_s  [1:SQRT_STEPS];
	logic [RAD_W-1:0] root_s [1:SQRT_STEPS];
	job_t             job_s  [1:SQRT_STEPS];
	logic             vld_s  [1:SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam int SH = RAD_W - 2 - 2 * k;
		logic [RAD_W-1:0] rad_in;
		logic [RAD_W-1:0] root_in;
		job_t             job_in;
		logic             vld_in;
		logic [RAD_W-1:0] bit_v;
		logic [RAD_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rad_in  = in_rad;
			assign root_in = '0;
			assign job_in  = in_job;
			assign vld_in  = in_vld;
		end else begin : g_rest
			assign rad_in  = rad_s[k];
			assign root_in = root_s[k];
			assign job_in  = job_s[k];
			assign vld_in  = vld_s[k];
		end

		assign bit_v = RAD_W'(1) << SH;
		assign trial = root_in + bit_v;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rad_in >= trial) begin
					rad_s[k+1]  <= rad_in - trial;
					root_s[k+1] <= (root_in >> 1) + bit_v;
				end else begin
					rad_s[k+1]  <= rad_in;
					root_s[k+1] <= root_in >> 1;
				end
				job_s[k+1] <= job_in;
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS];
	assign out_root = root_s[SQRT_STEPS][ROOT_W-1:0];
	assign out_job  = job_s[SQRT_STEPS];

endmodule

// ===== rtl/rqid_div.sv =====
// pipelined saturating fixed-point divider, one quotient bit per stage
// depends on rqid_pkg
module rqid_div import rqid_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] in_num,
	input  logic [NUM_W-1:0] in_den,
	input  ctl_t             in_ctl,
	output logic             out_vld,
	output result_t          out_res
);

	logic [REM_W-1:0]  rem_s  [0:DIV_STEPS];
	logic [NUM_W-1:0]  den_s  [0:DIV_STEPS];
	logic [DIST_W-1:0] quot_s [0:DIV_STEPS];
	logic              sat_s  [0:DIV_STEPS];
	ctl_t              ctl_s  [0:DIV_STEPS];
	logic              vld_s  [0:DIV_STEPS];

	logic [REM_W-1:0] num_sh;
	logic [REM_W-1:0] den_top;

	// quotient of 2^32 or more saturates
	assign num_sh  = REM_W'(in_num) << FRAC_BITS;
	assign den_top = REM_W'(in_den) << DIV_STEPS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_sh;
			den_s[0]  <= in_den;
			quot_s[0] <= '0;
			sat_s[0]  <= (num_sh >= den_top);
			ctl_s[0]  <= in_ctl;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		localparam int BIT = DIV_STEPS - k;
		logic [REM_W-1:0] dsh;

		assign dsh = REM_W'(den_s[k-1]) << BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k-1] >= dsh) begin
					rem_s[k]  <= rem_s[k-1] - dsh;
					quot_s[k] <= quot_s[k-1] | (DIST_W'(1) << BIT);
				end else begin
					rem_s[k]  <= rem_s[k-1];
					quot_s[k] <= quot_s[k-1];
				end
				den_s[k] <= den_s[k-1];
				sat_s[k] <= sat_s[k-1];
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	assign out_vld          = vld_s[DIV_STEPS];
	assign out_res.hits     = ctl_s[DIV_STEPS].hit;
	assign out_res.distance = !ctl_s[DIV_STEPS].do_div ? '0 :
		(sat_s[DIV_STEPS] ? '1 : quot_s[DIV_STEPS]);

endmodule

// ===== rtl/ray_quadric_intersect_distance.sv =====
// top level: ray against quadric hit test and distance to intercept
// depends on rqid_pkg, rqid_sqrt, rqid_div
//
// usage
// - query channel carries coefficients A, B, C (signed Q16.16) and the sense
// - result channel carries the hit flag and the saturating unsigned distance
// - one result per query, in order, no state kept between queries
// - a query transfers when query_valid is high and query_stall is low
// - a result transfers when result_valid is high and result_stall is low
// - pipeline order: the products register, the discriminant subtract register,
//   32 root stages (one result bit each), an operand setup register, the
//   divider's saturation check register and 32 quotient stages
// - throughput is one query per cycle unless a result is held; the root and
//   divider pipelines are the depth, a new query enters each cycle unless held
// - when the receiver stalls a waiting result, the whole pipeline holds and
//   query_stall rises in the same cycle; bubbles move on when it clears
// - reset clears all valid bits; no clearing pass, the block takes queries
//   right after reset
module ray_quadric_intersect_distance import rqid_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_stall,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// pipeline advance: anything but a held result moves
	logic en;
	assign en          = !result_valid || !result_stall;
	assign query_stall = !en;

	// stage 1: products and branch decision
	logic signed [RAD_W-1:0] bb_c;
	logic signed [RAD_W-1:0] ac_c;
	job_t                    job_c;
	logic signed [RAD_W-1:0] bb_s1;
	logic signed [RAD_W-1:0] ac_s1;
	job_t                    job_s1;
	logic                    vld_s1;

	// operands are sign extended 32-bit values, so each product is 32 by 32
	assign bb_c = RAD_W'(query.coef_b) * RAD_W'(query.coef_b);
	assign ac_c = RAD_W'(query.coef_a) * RAD_W'(query.coef_c);

	always_comb begin
		logic a_pos, a_neg, b_pos, b_neg, c_pos, c_neg;
		a_neg = query.coef_a[COEF_W-1];
		b_neg = query.coef_b[COEF_W-1];
		c_neg = query.coef_c[COEF_W-1];
		a_pos = !a_neg && (query.coef_a != '0);
		b_pos = !b_neg && (query.coef_b != '0);
		c_pos = !c_neg && (query.coef_c != '0);
		job_c.abs_a = a_neg ? -{1'b1, query.coef_a} : {1'b0, query.coef_a};
		job_c.abs_b = b_neg ? -{1'b1, query.coef_b} : {1'b0, query.coef_b};
		job_c.abs_c = c_neg ? -{1'b1, query.coef_c} : {1'b0, query.coef_c};
		if (!query.outside_sense) begin
			// inside: heading in when b <= 0 needs a > 0
			if (!b_pos) begin
				job_c.hit      = a_pos;
				job_c.do_div   = a_pos;
				job_c.root_num = 1'b1;
			end else begin
				job_c.hit      = 1'b1;
				job_c.do_div   = c_neg;
				job_c.root_num = 1'b0;
			end
		end else begin
			// outside: mirror image of the inside case
			if (!b_neg) begin
				job_c.hit      = a_neg;
				job_c.do_div   = a_neg;
				job_c.root_num = 1'b1;
			end else begin
				job_c.hit      = 1'b1;
				job_c.do_div   = c_pos;
				job_c.root_num = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1  <= bb_c;
			ac_s1  <= ac_c;
			job_s1 <= job_c;
		end
	end

	// stage 2: exact discriminant, miss on negative
	logic signed [RAD_W:0] disc_c;
	logic                  disc_neg;
	job_t                  job_gate_c;
	logic [RAD_W-1:0]      rad_s2;
	job_t                  job_s2;
	logic                  vld_s2;

	assign disc_c   = {bb_s1[RAD_W-1], bb_s1} - {ac_s1[RAD_W-1], ac_s1};
	assign disc_neg = disc_c[RAD_W];

	always_comb begin
		job_gate_c        = job_s1;
		job_gate_c.hit    = job_s1.hit && !disc_neg;
		job_gate_c.do_div = job_s1.do_div && !disc_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= disc_neg ? '0 : disc_c[RAD_W-1:0];
			job_s2 <= job_gate_c;
		end
	end

	// square root pipeline
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	job_t              sq_job;

	rqid_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_rad   (rad_s2),
		.in_job   (job_s2),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_job  (sq_job)
	);

	// stage 3: numerator and denominator
	logic [NUM_W-1:0] root_sum;
	logic [NUM_W-1:0] num_s3;
	logic [NUM_W-1:0] den_s3;
	ctl_t             ctl_s3;
	logic             vld_s3;

	assign root_sum = NUM_W'(sq_root) + NUM_W'(sq_job.abs_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= sq_job.root_num ? root_sum : NUM_W'(sq_job.abs_c);
			den_s3 <= sq_job.root_num ? NUM_W'(sq_job.abs_a) : root_sum;
			ctl_s3 <= '{hit: sq_job.hit, do_div: sq_job.do_div};
		end
	end

	// divider pipeline, its last stage is the result register
	rqid_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_num  (num_s3),
		.in_den  (den_s3),
		.in_ctl  (ctl_s3),
		.out_vld (result_valid),
		.out_res (result)
	);

	// a divide only happens on a hit
	a_div_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && ctl_s3.do_div |-> ctl_s3.hit)
		else $error("divide requested on a miss");

	// no divide by zero ever reaches the divider
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && ctl_s3.do_div |-> den_s3 != '0)
		else $error("zero denominator on a divide");

	// a miss always reports distance zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hits |-> result.distance == '0)
		else $error("nonzero distance on a miss");

	// a held result freezes the front of the pipeline
	a_hold_front: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(vld_s1) && $stable(vld_s3))
		else $error("pipeline moved while result held");

endmodule

// ===== test/tb_ray_quadric_intersect_distance.sv =====
// testbench for the ray/quadric intercept distance pipeline
// depends on rqid_pkg and ray_quadric_intersect_distance; self-checking, no files
// predicts hit flag and distance per query, checks results in order under random idling
class intercept_scoreboard;
	rqid_pkg::result_t pending[$];
	int mismatches;
	int checked;

	// floor square root of a non-negative 64-bit value, bit by bit
	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= v && t <= 64'hFFFF_FFFF)
				r = t;
		end
		return r;
	endfunction

	// (num << 16) / den saturated to 32 bits
	function automatic logic [31:0] quotient_sat(logic [63:0] num, logic [63:0] den);
		logic [127:0] q;
		if (den == 0)
			return 32'hFFFF_FFFF;
		q = ({64'd0, num} << 16) / {64'd0, den};
		return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic rqid_pkg::result_t intercept(rqid_pkg::query_t x);
		rqid_pkg::result_t r;
		longint a;
		longint b;
		longint c;
		longint disc;
		logic [63:0] s;
		a = x.coef_a;
		b = x.coef_b;
		c = x.coef_c;
		disc = b * b - a * c;
		r = '0;
		if (disc >= 0) begin
			s = root_floor(disc);
			if (!x.outside_sense) begin
				if (b <= 0) begin
					if (a > 0) begin
						r.hits = 1;
						r.distance = quotient_sat(s + (-b), a);
					end
				end else begin
					r.hits = 1;
					if (c < 0)
						r.distance = quotient_sat(-c, s + b);
				end
			end else begin
				if (b >= 0) begin
					if (a < 0) begin
						r.hits = 1;
						r.distance = quotient_sat(s + b, -a);
					end
				end else begin
					r.hits = 1;
					if (c > 0)
						r.distance = quotient_sat(c, s + (-b));
				end
			end
		end
		return r;
	endfunction

	function void note_query(rqid_pkg::query_t x);
		pending.push_back(intercept(x));
	endfunction

	function void check_result(rqid_pkg::result_t got);
		rqid_pkg::result_t want;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result hits=%0d distance=%h", got.hits, got.distance);
			return;
		end
		want = pending.pop_front();
		if (got.hits !== want.hits || got.distance !== want.distance) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected hits=%0d distance=%h, got hits=%0d distance=%h",
					want.hits, want.distance, got.hits, got.distance);
		end
	endfunction
endclass

module tb_ray_quadric_intersect_distance;
	import rqid_pkg::*;

	localparam int LATENCY     = 68;
	localparam int CYCLE_LIMIT = 400000;

	logic    clk;
	logic    arst_n;
	logic    query_valid;
	logic    query_stall;
	query_t  query;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	intercept_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	bit timed_out;
	int cycles;

	ray_quadric_intersect_distance dut (
		.clk(clk), .arst_n(arst_n),
		.query_valid(query_valid), .query_stall(query_stall), .query(query),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT && !timed_out) begin
			timed_out <= 1;
			$display("timeout after %0d cycles", cycles);
			$display("tb_ray_quadric_intersect_distance failed");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1;
		end else begin
			if (result_valid && !result_stall)
				board.check_result(result);
			result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// pick a coefficient: small values, full-range random values and a few extremes
	function automatic logic [31:0] pick_coef();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	// one transfer on the query channel, then optional idle cycles
	task automatic send_query(query_t x);
		query_valid <= 1;
		query <= x;
		do @(posedge clk); while (query_stall);
		board.note_query(x);
		if ($urandom_range(99) < send_idle_pct) begin
			query_valid <= 0;
			query <= '0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_random(int n);
		query_t x;
		for (int i = 0; i < n; i++) begin
			x.coef_a = pick_coef();
			x.coef_b = pick_coef();
			x.coef_c = pick_coef();
			x.outside_sense = 1'($urandom_range(1));
			send_query(x);
		end
	endtask

	task automatic drain();
		query_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_directed();
		logic [31:0] ext[4];
		query_t x;
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000};
		// extremes and each sign branch, both senses
		for (int s = 0; s < 2; s++) begin
			x = '{ext[0], ext[1], ext[0], s[0]}; send_query(x);
			x = '{ext[1], ext[0], ext[1], s[0]}; send_query(x);
			x = '{ext[2], ext[2], ext[2], s[0]}; send_query(x);
			// positive a, negative b: inside hit by root branch
			x = '{32'h0001_0000, -32'sh0002_0000, 32'h0001_0000, s[0]}; send_query(x);
			// zero a, nonpositive b: inside miss
			x = '{32'h0, -32'sh0001_0000, 32'h0, s[0]}; send_query(x);
			// positive b with negative and positive c
			x = '{32'h0001_0000, 32'h0002_0000, -32'sh0003_0000, s[0]}; send_query(x);
			x = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, s[0]}; send_query(x);
			// negative a, positive b: outside root branch
			x = '{-32'sh0001_0000, 32'h0002_0000, 32'h0001_0000, s[0]}; send_query(x);
			// negative b, positive c
			x = '{32'h0001_0000, -32'sh0002_0000, 32'h0003_0000, s[0]}; send_query(x);
			// negative discriminant: miss
			x = '{32'h0004_0000, 32'h0001_0000, 32'h0004_0000, s[0]}; send_query(x);
			// tiny a: saturated distance
			x = '{32'h0000_0001, -32'sh7FFF_0000, 32'h0, s[0]}; send_query(x);
			x = '{32'hFFFF_FFFF, 32'h7FFF_0000, 32'h0, s[0]}; send_query(x);
		end
	endtask

	initial begin
		board = new();
		arst_n = 0;
		query_valid = 0;
		query = '0;
		hold_off = 0;
		timed_out = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_directed();
		drain();

		send_idle_pct = 36;
		recv_idle_pct = 66;
		send_random(450);
		// sender pauses until everything is back
		drain();

		// long receiver hold-off while queries keep coming, fills the pipeline
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			begin
				send_idle_pct = 0;
				send_random(120);
			end
		join

		send_idle_pct = 66;
		recv_idle_pct = 36;
		send_random(430);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(430);

		drain();
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered directed sign branches and extremes plus %0d random queries",
			1430);
		$display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_ray_quadric_intersect_distance passed");
		else
			$display("tb_ray_quadric_intersect_distance failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/rqid_pkg.sv
rtl/rqid_sqrt.sv
rtl/rqid_div.sv
rtl/ray_quadric_intersect_distance.sv
test/tb_ray_quadric_intersect_distance.sv
